// ===== rtl/core/stb_pkg.sv =====
// Shared types, constants and elaboration-time tables for the sine tone burst generator.
// Holds the quarter-wave sine magnitudes and the phase step fractions.
// Used by stb_sine_scale, stb_step_calc and sine_tone_burst_generator_top.
`timescale 1ns / 1ps
`default_nettype none

package stb_pkg;

    // Field and state widths
    localparam int PHASE_W   = 32;
    localparam int TONE_W    = 21;
    localparam int TAIL_W    = 9;
    localparam int FREQ_W    = 16;
    localparam int DUR_W     = 16;
    localparam int AMP_W     = 15;
    localparam int SAMPLE_W  = 16;
    localparam int IDX_W     = 10;
    localparam int QIDX_W    = 8;
    localparam int FRAC_W    = 25;

    // Zero samples that follow a tone with the amplifier still on
    localparam logic [TAIL_W-1:0] TAIL_SAMPLES = 9'd320;

    // Register reset values
    localparam logic [AMP_W-1:0] AMPLITUDE_RESET = 15'd3000;

    // ceil(2^23 / 125): exact quotient by 125 for every 16-bit frequency
    localparam logic [16:0] RECIP_125 = 17'd67109;
    localparam int          RECIP_SHIFT = 23;

    // pi/2 in Q2.30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Burst modes
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_TONE    = 2'd1;
    localparam logic [1:0] MODE_SILENCE = 2'd2;
    localparam logic [1:0] MODE_TAIL    = 2'd3;

    // Input kinds
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // Configuration register indexes
    localparam logic CFG_AMPLITUDE = 1'b0;
    localparam logic CFG_ENABLE    = 1'b1;

    typedef logic [AMP_W-1:0]  qtab_t [256];
    typedef logic [FRAC_W-1:0] frac_tab_t [128];

    // Magnitude of round(32767*sin(a*pi/2048)) for a in 0..1024, using a
    // five-term odd series in Q30 arithmetic.
    function automatic logic [AMP_W-1:0] quarter_mag(input logic [63:0] a);
        logic [63:0] x;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] mag;
        x    = (a * HALF_PI_Q30) >> 10;
        sum  = x;
        term = x;
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd6;
        sum  = sum - term;
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd20;
        sum  = sum + term;
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd42;
        sum  = sum - term;
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd72;
        sum  = sum + term;
        mag  = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (mag > 64'd32767) begin
            mag = 64'd32767;
        end
        return mag[AMP_W-1:0];
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int j = 0; j < 256; j++) begin
            t[j] = quarter_mag(64'(j) * 64'd4);
        end
        return t;
    endfunction

    // floor(b * 2^25 / 125) for each remainder b of the frequency by 125
    function automatic frac_tab_t build_frac();
        frac_tab_t t;
        for (int b = 0; b < 128; b++) begin
            t[b] = FRAC_W'((64'(b) << 25) / 64'd125);
        end
        return t;
    endfunction

    localparam qtab_t            QTAB      = build_qtab();
    localparam logic [AMP_W-1:0] QMAG_FULL = quarter_mag(64'd1024);
    localparam frac_tab_t        FRAC_TAB  = build_frac();

endpackage

`default_nettype wire

// ===== rtl/core/stb_sine_scale.sv =====
// Sine lookup and amplitude scaling for one tone sample.
// Quarter-wave table from stb_pkg, one 15x15 multiply, sign restore.
// Depends on stb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stb_sine_scale (
    input  wire logic [stb_pkg::IDX_W-1:0]    phase_idx,
    input  wire logic [stb_pkg::AMP_W-1:0]    amplitude,
    output logic signed [stb_pkg::SAMPLE_W-1:0] sample
);

    logic [1:0]                    quad;
    logic [stb_pkg::QIDX_W-1:0]    j;
    logic [stb_pkg::QIDX_W-1:0]    j_mirror;
    logic [stb_pkg::AMP_W-1:0]     mag;
    logic [2*stb_pkg::AMP_W-1:0]   prod;
    logic [stb_pkg::AMP_W-1:0]     scaled;

    assign quad     = phase_idx[stb_pkg::IDX_W-1 -: 2];
    assign j        = phase_idx[stb_pkg::QIDX_W-1:0];
    assign j_mirror = stb_pkg::QIDX_W'(~j + 1'b1);

    // Fold the index onto the first quarter wave; the falling quarters
    // read the table backwards and hit the peak when the offset is zero.
    always_comb begin
        if (quad[0]) begin
            mag = (j == '0) ? stb_pkg::QMAG_FULL : stb_pkg::QTAB[j_mirror];
        end else begin
            mag = stb_pkg::QTAB[j];
        end
    end

    // Scale the magnitude, truncate, then restore the sign of the half wave.
    assign prod   = mag * amplitude;
    assign scaled = prod[2*stb_pkg::AMP_W-1 -: stb_pkg::AMP_W];

    always_comb begin
        if (quad[1]) begin
            sample = -$signed({1'b0, scaled});
        end else begin
            sample = $signed({1'b0, scaled});
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/stb_step_calc.sv =====
// Phase increment for a start request: floor(freq * 2^32 / 16000) mod 2^32.
// Splits freq into 125*a + b; a by reciprocal multiply, b through a table.
// Depends on stb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stb_step_calc (
    input  wire logic [stb_pkg::FREQ_W-1:0]  freq_hz,
    output logic [stb_pkg::PHASE_W-1:0]      phase_step
);

    logic [stb_pkg::FREQ_W+16:0] recip_prod;
    logic [9:0]                  quot;
    logic [16:0]                 quot_x125;
    logic [stb_pkg::FREQ_W-1:0]  rem_wide;
    logic [6:0]                  rem;

    // Quotient by 125 through a reciprocal multiply, exact over 16 bits.
    assign recip_prod = freq_hz * stb_pkg::RECIP_125;
    assign quot       = recip_prod[stb_pkg::RECIP_SHIFT +: 10];

    // Remainder, always below 125.
    assign quot_x125  = (17'(quot) << 7) - (17'(quot) << 1) - 17'(quot);
    assign rem_wide   = freq_hz - quot_x125[stb_pkg::FREQ_W-1:0];
    assign rem        = rem_wide[6:0];

    // a * 2^25 keeps only its low bits modulo 2^32; the fraction fills below.
    assign phase_step = {quot[6:0], stb_pkg::FRAC_TAB[rem]};

endmodule

`default_nettype wire

// ===== rtl/core/sine_tone_burst_generator_top.sv =====
// Sine tone burst generator: direct digital synthesis of PCM tone bursts.
//
// Input stream (s_*): s_tuser selects the request kind. A start request
// loads a frequency and a duration; a tick request yields one sample.
// Starts produce no result; every tick produces exactly one result on the
// output stream (m_*), which carries the sample, the amplifier level and
// the busy flag, with m_tlast marking the final sample of a burst.
// A tone lasts 16 samples per millisecond and is followed by 320 zero
// samples with the amplifier still on; frequency zero gives silence.
// Starts while busy or disabled are dropped.
// A tick's result is registered and shows in the cycle after the tick is
// accepted. One request per cycle while the receiver takes results; the
// phase accumulator, the quarter-wave lookup and one 15x15 multiply sit
// between the state registers and the output register.
// A stalled receiver holds the output register; a new request is taken
// whenever that register is empty or being drained in the same cycle.
// Reset (aresetn low, synchronous) returns to idle with amplitude 3000
// and enable set. The configuration channel is always ready.
`timescale 1ns / 1ps
`default_nettype none

module sine_tone_burst_generator_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] freq_hz, [31:16] tone_ms
    input  wire logic        s_tuser,   // [0] cmd
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [15:0] sample, [16] amp_on, [17] busy_res, zeros
    output logic             m_tlast,
    // Configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int TOTAL_W = stb_pkg::DUR_W + 4;

    // Configuration registers
    logic [stb_pkg::AMP_W-1:0]   amplitude_reg;
    logic                        enable_reg;

    // Burst state
    logic [stb_pkg::PHASE_W-1:0] phase_acc_reg,  phase_acc_next;
    logic [stb_pkg::PHASE_W-1:0] phase_step_reg, phase_step_next;
    logic [stb_pkg::TONE_W-1:0]  tone_left_reg,  tone_left_next;
    logic [stb_pkg::TAIL_W-1:0]  tail_left_reg,  tail_left_next;
    logic [1:0]                  mode_reg,       mode_next;

    // Output register
    logic                        m_valid_reg, m_valid_next;
    logic [stb_pkg::SAMPLE_W-1:0] sample_reg, sample_next;
    logic                        amp_on_reg, amp_on_next;
    logic                        busy_reg,   busy_next;
    logic                        last_reg,   last_next;

    logic                        s_fire;
    logic [stb_pkg::FREQ_W-1:0]  freq_hz;
    logic [stb_pkg::DUR_W-1:0]   tone_ms;
    logic [TOTAL_W-1:0]          total;
    logic [stb_pkg::PHASE_W-1:0] step_calc;
    logic signed [stb_pkg::SAMPLE_W-1:0] tone_sample;

    assign freq_hz     = s_tdata[15:0];
    assign tone_ms     = s_tdata[31:16];
    // 16000 samples per second is exactly 16 per millisecond.
    assign total       = {tone_ms, 4'b0000};

    assign s_tready  = !m_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, busy_reg, amp_on_reg, sample_reg};
    assign m_tlast  = last_reg;

    stb_step_calc u_step (
        .freq_hz    (freq_hz),
        .phase_step (step_calc)
    );

    stb_sine_scale u_sine (
        .phase_idx (phase_acc_reg[stb_pkg::PHASE_W-1 -: stb_pkg::IDX_W]),
        .amplitude (amplitude_reg),
        .sample    (tone_sample)
    );

    // Burst sequencing and result formation for each accepted request.
    always_comb begin
        phase_acc_next  = phase_acc_reg;
        phase_step_next = phase_step_reg;
        tone_left_next  = tone_left_reg;
        tail_left_next  = tail_left_reg;
        mode_next       = mode_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        sample_next     = sample_reg;
        amp_on_next     = amp_on_reg;
        busy_next       = busy_reg;
        last_next       = last_reg;

        if (s_fire) begin
            unique case (s_tuser)
                stb_pkg::CMD_START: begin
                    if (enable_reg && mode_reg == stb_pkg::MODE_IDLE) begin
                        tone_left_next = stb_pkg::TONE_W'(total);
                        if (freq_hz == '0) begin
                            mode_next = (total != '0) ? stb_pkg::MODE_SILENCE
                                                      : stb_pkg::MODE_IDLE;
                        end else begin
                            phase_acc_next  = '0;
                            phase_step_next = step_calc;
                            if (total != '0) begin
                                mode_next = stb_pkg::MODE_TONE;
                            end else if (stb_pkg::TAIL_SAMPLES != '0) begin
                                tail_left_next = stb_pkg::TAIL_SAMPLES;
                                mode_next      = stb_pkg::MODE_TAIL;
                            end else begin
                                mode_next = stb_pkg::MODE_IDLE;
                            end
                        end
                    end
                end
                stb_pkg::CMD_TICK: begin
                    m_valid_next = 1'b1;
                    sample_next  = '0;
                    amp_on_next  = 1'b0;
                    busy_next    = 1'b0;
                    last_next    = 1'b0;
                    unique case (mode_reg)
                        stb_pkg::MODE_TONE: begin
                            sample_next    = tone_sample;
                            amp_on_next    = 1'b1;
                            busy_next      = 1'b1;
                            phase_acc_next = phase_acc_reg + phase_step_reg;
                            tone_left_next = tone_left_reg - 1'b1;
                            if (tone_left_reg == stb_pkg::TONE_W'(1)) begin
                                if (stb_pkg::TAIL_SAMPLES != '0) begin
                                    tail_left_next = stb_pkg::TAIL_SAMPLES;
                                    mode_next      = stb_pkg::MODE_TAIL;
                                end else begin
                                    mode_next = stb_pkg::MODE_IDLE;
                                    last_next = 1'b1;
                                end
                            end
                        end
                        stb_pkg::MODE_SILENCE: begin
                            busy_next      = 1'b1;
                            tone_left_next = tone_left_reg - 1'b1;
                            if (tone_left_reg == stb_pkg::TONE_W'(1)) begin
                                mode_next = stb_pkg::MODE_IDLE;
                                last_next = 1'b1;
                            end
                        end
                        stb_pkg::MODE_TAIL: begin
                            amp_on_next    = 1'b1;
                            busy_next      = 1'b1;
                            tail_left_next = tail_left_reg - 1'b1;
                            if (tail_left_reg == stb_pkg::TAIL_W'(1)) begin
                                mode_next = stb_pkg::MODE_IDLE;
                                last_next = 1'b1;
                            end
                        end
                        default: begin
                            // Idle: all-zero result
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // State and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg  <= '0;
            phase_step_reg <= '0;
            tone_left_reg  <= '0;
            tail_left_reg  <= '0;
            mode_reg       <= stb_pkg::MODE_IDLE;
            m_valid_reg    <= 1'b0;
        end else begin
            phase_acc_reg  <= phase_acc_next;
            phase_step_reg <= phase_step_next;
            tone_left_reg  <= tone_left_next;
            tail_left_reg  <= tail_left_next;
            mode_reg       <= mode_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        amp_on_reg <= amp_on_next;
        busy_reg   <= busy_next;
        last_reg   <= last_next;
    end

    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amplitude_reg <= stb_pkg::AMPLITUDE_RESET;
            enable_reg    <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                stb_pkg::CFG_AMPLITUDE: amplitude_reg <= cfg_data[stb_pkg::AMP_W-1:0];
                stb_pkg::CFG_ENABLE:    enable_reg    <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // A running mode always has samples left to give.
    a_counts_live: assert property (@(posedge aclk) disable iff (!aresetn)
        ((mode_reg == stb_pkg::MODE_TONE || mode_reg == stb_pkg::MODE_SILENCE)
            |-> tone_left_reg != '0) and
        (mode_reg == stb_pkg::MODE_TAIL |-> tail_left_reg != '0))
        else $error("burst mode active with an exhausted counter");

    // A tick taken while a burst runs gives a busy result.
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tuser == stb_pkg::CMD_TICK && mode_reg != stb_pkg::MODE_IDLE
            |=> m_valid_reg && busy_reg)
        else $error("tick during a burst did not give a busy result");

    // A tick taken while idle gives an all-zero result.
    a_tick_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tuser == stb_pkg::CMD_TICK && mode_reg == stb_pkg::MODE_IDLE
            |=> m_valid_reg && !busy_reg && !amp_on_reg && !last_reg && sample_reg == '0)
        else $error("idle tick gave a non-zero result");

    // A start taken during a burst leaves the burst untouched.
    a_start_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tuser == stb_pkg::CMD_START && mode_reg != stb_pkg::MODE_IDLE
            |=> $stable(mode_reg) && $stable(tone_left_reg) && $stable(phase_acc_reg))
        else $error("start during a burst changed the burst state");

    // Audible samples only come with the amplifier on, and the end of a
    // burst is always a busy sample.
    a_flags_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (sample_reg == '0 || amp_on_reg) && (!last_reg || busy_reg))
        else $error("result flags inconsistent with the sample");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for sine_tone_burst_generator_top: drives start and tick requests
// and register writes, and compares every PCM sample with an in-bench prediction.
// Depends on stb_pkg and the generator RTL only.
`timescale 1ns / 1ps

module tb_top;
    import stb_pkg::*;

    localparam int RUN_LIMIT      = 500000;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int SINE_ENTRIES   = 1 << IDX_W;
    localparam int RATE_HZ        = 16000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] pcm;
        logic                amp_on;
        logic                busy;
        logic                fin;
    } pcm_result_t;

    // Predicts the burst generator and holds the samples still owed by it.
    class burst_scoreboard;
        int                 sine_q15 [SINE_ENTRIES];
        logic [AMP_W-1:0]   amplitude;
        logic               enabled;
        logic [PHASE_W-1:0] phase;
        logic [PHASE_W-1:0] step;
        logic [TONE_W-1:0]  tone_left;
        logic [TAIL_W-1:0]  tail_left;
        logic [1:0]         mode;
        pcm_result_t        due_samples [$];
        int                 failures;

        function new();
            for (int i = 0; i < SINE_ENTRIES; i++) begin
                sine_q15[i] = sine_entry(i);
            end
            amplitude = AMPLITUDE_RESET;
            enabled   = 1'b1;
            phase     = '0;
            step      = '0;
            tone_left = '0;
            tail_left = '0;
            mode      = MODE_IDLE;
            failures  = 0;
        endfunction

        // Q1.15 sine of entry i: the quarter wave is folded, then an odd series in Q30.
        function int sine_entry(int unsigned i);
            longint unsigned u;
            longint unsigned quad;
            longint unsigned r;
            longint unsigned a;
            longint unsigned x;
            longint unsigned sum;
            longint unsigned term;
            longint unsigned mag;
            u    = longint'(i) * 4;
            quad = u / SINE_ENTRIES;
            r    = u % SINE_ENTRIES;
            a    = quad[0] ? (SINE_ENTRIES - r) : r;
            x    = (a * HALF_PI_Q30) / SINE_ENTRIES;
            sum  = x;
            term = x;
            for (int k = 1; k <= 4; k++) begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / longint'((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            mag = (sum * 32767 + (64'd1 << 29)) >> 30;
            if (mag > 32767) begin
                mag = 32767;
            end
            return (quad >= 2) ? -int'(mag) : int'(mag);
        endfunction

        function void write_register(logic idx, logic [15:0] data);
            if (idx == CFG_AMPLITUDE) begin
                amplitude = data[AMP_W-1:0];
            end else begin
                enabled = data[0];
            end
        endfunction

        // Applies one accepted request; returns 1 when the block ignores it.
        function bit note_request(logic cmd, logic [FREQ_W-1:0] freq, logic [DUR_W-1:0] dur);
            logic [TONE_W-1:0] total;
            int                table_val;
            int unsigned       mag;
            int                pcm;
            pcm_result_t       r;
            if (cmd == CMD_START) begin
                if (!enabled || mode != MODE_IDLE) begin
                    return 1'b1;
                end
                total     = TONE_W'((longint'(dur) * RATE_HZ) / 1000);
                tone_left = total;
                if (freq == 0) begin
                    mode = (total != 0) ? MODE_SILENCE : MODE_IDLE;
                end else begin
                    phase = '0;
                    step  = PHASE_W'((64'(freq) << PHASE_W) / 64'(RATE_HZ));
                    if (total != 0) begin
                        mode = MODE_TONE;
                    end else if (TAIL_SAMPLES != 0) begin
                        tail_left = TAIL_SAMPLES;
                        mode      = MODE_TAIL;
                    end else begin
                        mode = MODE_IDLE;
                    end
                end
                return 1'b0;
            end

            // A tick always yields one sample.
            r = '0;
            case (mode)
                MODE_TONE: begin
                    table_val = sine_q15[phase[PHASE_W-1 -: IDX_W]];
                    mag       = (table_val < 0) ? -table_val : table_val;
                    pcm       = int'((mag * amplitude) >> 15);
                    if (table_val < 0) begin
                        pcm = -pcm;
                    end
                    phase     = phase + step;
                    tone_left = tone_left - 1'b1;
                    r.pcm     = pcm[SAMPLE_W-1:0];
                    r.amp_on  = 1'b1;
                    r.busy    = 1'b1;
                    if (tone_left == 0) begin
                        if (TAIL_SAMPLES != 0) begin
                            tail_left = TAIL_SAMPLES;
                            mode      = MODE_TAIL;
                        end else begin
                            mode  = MODE_IDLE;
                            r.fin = 1'b1;
                        end
                    end
                end
                MODE_SILENCE: begin
                    tone_left = tone_left - 1'b1;
                    r.busy    = 1'b1;
                    if (tone_left == 0) begin
                        mode  = MODE_IDLE;
                        r.fin = 1'b1;
                    end
                end
                MODE_TAIL: begin
                    tail_left = tail_left - 1'b1;
                    r.amp_on  = 1'b1;
                    r.busy    = 1'b1;
                    if (tail_left == 0) begin
                        mode  = MODE_IDLE;
                        r.fin = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            due_samples.push_back(r);
            return 1'b0;
        endfunction

        function void check_result(logic [23:0] data, logic tlast);
            pcm_result_t e;
            if (due_samples.size() == 0) begin
                $error("unexpected result: sample %0d", $signed(data[15:0]));
                failures++;
                return;
            end
            e = due_samples.pop_front();
            if (data[15:0] !== e.pcm) begin
                $error("sample: expected %0d, got %0d", $signed(e.pcm), $signed(data[15:0]));
                failures++;
            end
            if (data[16] !== e.amp_on) begin
                $error("amp_on: expected %0b, got %0b", e.amp_on, data[16]);
                failures++;
            end
            if (data[17] !== e.busy) begin
                $error("busy_res: expected %0b, got %0b", e.busy, data[17]);
                failures++;
            end
            if (tlast !== e.fin) begin
                $error("last: expected %0b, got %0b", e.fin, tlast);
                failures++;
            end
        endfunction

        function int pending();
            return due_samples.size();
        endfunction

        function bit in_burst();
            return mode != MODE_IDLE;
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;

    bit              no_idle = 1'b0;
    int              cycles = 0;
    int              items_sent = 0;
    int              random_base;
    int unsigned     pick;
    burst_scoreboard sb = new();

    sine_tone_burst_generator_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock.
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result receiver: stalls at random except during the quiet stretch.
    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 14);
    end

    // Every accepted result is checked against the oldest predicted sample.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tlast);
        end
    end

    // Sends one request, with an occasional gap first, and predicts it once accepted.
    task automatic push_request(input logic cmd, input logic [15:0] freq,
                                input logic [15:0] dur);
        bit ignored;
        if (!no_idle && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {dur, freq};
        do @(posedge aclk); while (!s_tready);
        ignored = sb.note_request(cmd, freq, dur);
        if (!ignored) begin
            items_sent++;
        end
        @(negedge aclk);
    endtask

    // Ticks carry random data in the unused fields.
    task automatic tick();
        push_request(CMD_TICK, 16'($urandom), 16'($urandom));
    endtask

    task automatic start_burst(input logic [15:0] freq, input logic [15:0] dur);
        push_request(CMD_START, freq, dur);
    endtask

    task automatic finish_burst();
        while (sb.in_burst()) begin
            tick();
        end
    endtask

    // Stops requests and waits until every owed sample has come out.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_register(input logic idx, input logic [15:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_register(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_freq();
        case ($urandom_range(0, 9))
            0, 1:       return 16'd0;
            2, 3, 4, 5: return 16'($urandom_range(1, RATE_HZ / 2));
            6: begin
                case ($urandom_range(0, 4))
                    0:       return 16'd1;
                    1:       return 16'd7999;
                    2:       return 16'd8000;
                    3:       return 16'd8001;
                    default: return 16'hFFFF;
                endcase
            end
            default:    return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_duration();
        if ($urandom_range(0, 9) == 0) begin
            return 16'($urandom_range(4, 12));
        end
        return 16'($urandom_range(0, 3));
    endfunction

    function automatic logic [15:0] pick_amplitude();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd32767;
            2:       return 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_TICK;
        cfg_valid = 1'b0;
        cfg_index = CFG_AMPLITUDE;
        cfg_data  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: idle tick, empty silence, short tone, zero-length tone.
        tick();
        start_burst(16'd0, 16'd0);
        tick();
        start_burst(16'd1000, 16'd1);
        finish_burst();
        start_burst(16'hFFFF, 16'd0);
        repeat (3) tick();
        // A start during the tail is dropped.
        start_burst(16'hFFFF, 16'hFFFF);
        finish_burst();
        start_burst(16'd0, 16'd2);
        finish_burst();
        start_burst(16'd8000, 16'd1);
        finish_burst();

        // Amplitude changes and enable cleared in the middle of a tone.
        write_register(CFG_AMPLITUDE, 16'd32767);
        start_burst(16'd440, 16'd2);
        repeat (5) tick();
        write_register(CFG_AMPLITUDE, 16'd0);
        repeat (5) tick();
        write_register(CFG_AMPLITUDE, 16'd1);
        repeat (5) tick();
        write_register(CFG_ENABLE, 16'd0);
        finish_burst();
        start_burst(16'd1234, 16'h8000);
        tick();
        write_register(CFG_ENABLE, 16'd1);
        write_register(CFG_AMPLITUDE, {1'b1, 15'd20000});

        // One long aliased tone, then a tone just below the sample rate.
        start_burst(16'd21845, 16'd2049);
        finish_burst();
        start_burst(16'd15999, 16'd1);
        finish_burst();

        // Random bursts with noise, stray starts and register writes.
        random_base = items_sent;
        while (items_sent - random_base < RANDOM_ITEMS) begin
            no_idle = (items_sent - random_base >= 500) && (items_sent - random_base < 800);
            pick    = $urandom_range(0, 99);
            if (sb.in_burst()) begin
                if (pick < 4) begin
                    start_burst(16'($urandom), 16'($urandom));
                end else if (pick < 5) begin
                    write_register(CFG_AMPLITUDE, pick_amplitude());
                end else if (pick < 6) begin
                    write_register(CFG_ENABLE, {15'($urandom), 1'($urandom_range(0, 1))});
                end else begin
                    tick();
                end
            end else begin
                if (pick < 60) begin
                    start_burst(pick_freq(), pick_duration());
                end else if (pick < 75) begin
                    repeat ($urandom_range(1, 4)) tick();
                end else if (pick < 85) begin
                    write_register(CFG_AMPLITUDE, pick_amplitude());
                end else if (pick < 90) begin
                    write_register(CFG_ENABLE,
                                   {15'($urandom), 1'($urandom_range(0, 2) != 0)});
                end else begin
                    start_burst(16'($urandom), 16'($urandom));
                    tick();
                end
            end
        end
        no_idle = 1'b0;

        settle();
        repeat (10) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
